FILE: rtl/lee_pkg.sv
// Shared types and constants for the LED effect engine.
// Used by every module of the block; no dependencies.
`default_nettype none

package lee_pkg;

  localparam int NUM_W      = 24;
  localparam int DEN_W      = 16;
  localparam int DIV_CNT_W  = 5;
  localparam int RAW_PROD_W = 15;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 19;
  localparam int SCALE_W    = RAW_PROD_W + RECIP_W;

  localparam logic [16:0] MAX_PERIOD_MS = 17'd120000;
  localparam logic [16:0] BREATHE_MIN   = 17'd100;
  localparam logic [15:0] BLINK_MIN     = 16'd50;
  localparam logic [15:0] BLINK_MAX     = 16'd60000;
  localparam logic [6:0]  LEVEL_MAX     = 7'd100;
  localparam logic [7:0]  STATUS_RAW    = 8'd50;
  localparam logic [7:0]  RAW_MAX_MIN   = 8'd1;
  localparam logic [RAW_PROD_W-1:0] ROUND_HALF = RAW_PROD_W'(50);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST   = DIV_CNT_W'(NUM_W - 1);
  // x / 100 == (x * 5243) >> 19 for any x below 2^15
  localparam logic [RECIP_W-1:0]    RECIP_100  = RECIP_W'(5243);

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_STEADY  = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_BREATHE = 3'd3,
    MODE_STATUS  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_PEAK      = 3'd1,
    REG_ON_TIME   = 3'd2,
    REG_OFF_TIME  = 3'd3,
    REG_PERIOD    = 3'd4,
    REG_RAW_MAX   = 3'd5,
    REG_CHANNEL   = 3'd6,
    REG_STATUS_EN = 3'd7
  } reg_idx_t;

  typedef struct packed {
    mode_t       effect_mode;
    logic [6:0]  peak_level;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [16:0] breathe_period_ms;
    logic [7:0]  raw_max;
    logic        channel;
    logic        show_status;
  } cfg_t;

  typedef struct packed {
    logic ext_power_lost;
    logic battery_full;
    logic charge_capped;
    logic battery_charging;
  } in_item_t;

  typedef struct packed {
    logic [7:0] raw_brightness;
    logic [6:0] user_level;
    logic       write_strobe;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_START1,
    ST_DIV1,
    ST_MUL2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic div_start;
    logic mul2;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lee_cfg.sv
// Configuration registers with saturation on write and effect restart pulse.
// Depends on lee_pkg.
`default_nettype none

module lee_cfg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [16:0]    cfg_data,
  output lee_pkg::cfg_t       cfg,
  output logic                restart
);

  lee_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lee_pkg::reg_idx_t'(cfg_index))
        lee_pkg::REG_MODE: begin
          if (cfg_data[2:0] > lee_pkg::MODE_STATUS) cfg_nxt.effect_mode = lee_pkg::MODE_STATUS;
          else cfg_nxt.effect_mode = lee_pkg::mode_t'(cfg_data[2:0]);
        end
        lee_pkg::REG_PEAK: begin
          if (cfg_data[6:0] > lee_pkg::LEVEL_MAX) cfg_nxt.peak_level = lee_pkg::LEVEL_MAX;
          else cfg_nxt.peak_level = cfg_data[6:0];
        end
        lee_pkg::REG_ON_TIME: begin
          if (cfg_data[15:0] < lee_pkg::BLINK_MIN) cfg_nxt.on_time_ms = lee_pkg::BLINK_MIN;
          else if (cfg_data[15:0] > lee_pkg::BLINK_MAX) cfg_nxt.on_time_ms = lee_pkg::BLINK_MAX;
          else cfg_nxt.on_time_ms = cfg_data[15:0];
        end
        lee_pkg::REG_OFF_TIME: begin
          if (cfg_data[15:0] < lee_pkg::BLINK_MIN) cfg_nxt.off_time_ms = lee_pkg::BLINK_MIN;
          else if (cfg_data[15:0] > lee_pkg::BLINK_MAX) cfg_nxt.off_time_ms = lee_pkg::BLINK_MAX;
          else cfg_nxt.off_time_ms = cfg_data[15:0];
        end
        lee_pkg::REG_PERIOD: begin
          if (cfg_data < lee_pkg::BREATHE_MIN) begin
            cfg_nxt.breathe_period_ms = lee_pkg::BREATHE_MIN;
          end else if (cfg_data > lee_pkg::MAX_PERIOD_MS) begin
            cfg_nxt.breathe_period_ms = lee_pkg::MAX_PERIOD_MS;
          end else begin
            cfg_nxt.breathe_period_ms = cfg_data;
          end
        end
        lee_pkg::REG_RAW_MAX: begin
          if (cfg_data[7:0] < lee_pkg::RAW_MAX_MIN) cfg_nxt.raw_max = lee_pkg::RAW_MAX_MIN;
          else cfg_nxt.raw_max = cfg_data[7:0];
        end
        lee_pkg::REG_CHANNEL:   cfg_nxt.channel = cfg_data[0];
        lee_pkg::REG_STATUS_EN: cfg_nxt.show_status = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_mode       <= lee_pkg::MODE_STATUS;
      cfg_r.peak_level        <= '0;
      cfg_r.on_time_ms        <= lee_pkg::BLINK_MIN;
      cfg_r.off_time_ms       <= lee_pkg::BLINK_MIN;
      cfg_r.breathe_period_ms <= lee_pkg::BREATHE_MIN;
      cfg_r.raw_max           <= 8'd100;
      cfg_r.channel           <= 1'b0;
      cfg_r.show_status       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // every index is a real register, so every write restarts the effect
  assign restart = cfg_we;
  assign cfg     = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/lee_div.sv
// Restoring divider, one quotient bit per cycle, used for the effect level.
// Depends on lee_pkg.
`default_nettype none

module lee_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lee_pkg::NUM_W-1:0]   num,
  input  wire logic [lee_pkg::DEN_W-1:0]   den,
  output logic      [lee_pkg::NUM_W-1:0]   quotient,
  output logic                             busy
);

  logic [lee_pkg::NUM_W-1:0]     dvd_r, dvd_nxt;
  logic [lee_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [lee_pkg::DEN_W-1:0]     den_r;
  logic [lee_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [lee_pkg::DEN_W:0]       trial;
  logic [lee_pkg::DEN_W:0]       diff;
  logic                          ge;

  assign trial = {rem_r, dvd_r[lee_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[lee_pkg::NUM_W-2:0], ge};
      rem_nxt = ge ? diff[lee_pkg::DEN_W-1:0] : trial[lee_pkg::DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lee_pkg::DIV_LAST) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign quotient = dvd_r;
  assign busy     = busy_r;

endmodule

`default_nettype wire

FILE: rtl/lee_dp.sv
// Datapath: effect state, operand multiplies, divider and result register.
// Depends on lee_pkg and lee_div.
`default_nettype none

module lee_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lee_pkg::cfg_t      cfg,
  input  wire logic               restart,
  input  wire lee_pkg::in_item_t  in_item,
  input  wire lee_pkg::cmd_t      cmd,
  output lee_pkg::sts_t           sts,
  output lee_pkg::out_item_t      out_item
);

  lee_pkg::in_item_t           in_r;
  lee_pkg::out_item_t          out_r;
  logic [16:0]                 elapsed_r, elapsed_nxt;
  logic                        phase_on_r, phase_on_nxt;
  logic [7:0]                  last_raw_r;
  logic                        last_valid_r;
  logic [lee_pkg::NUM_W-1:0]   op_num_r;
  logic [lee_pkg::DEN_W-1:0]   op_den_r;
  logic [6:0]                  level_r;
  logic [lee_pkg::RAW_PROD_W-1:0] raw_prod_r;

  logic [lee_pkg::NUM_W-1:0]   quotient;
  logic                        div_busy;

  logic [15:0]                 half;
  logic                        rising;
  logic [16:0]                 bre_op;
  logic [lee_pkg::NUM_W-1:0]   bre_prod;
  logic                        full, charging, stat_on;
  logic [7:0]                  stat_s, stat_lim;
  logic [lee_pkg::NUM_W-1:0]   stat_num;
  logic [lee_pkg::NUM_W-1:0]   num1;
  logic [lee_pkg::DEN_W-1:0]   den1;
  logic [6:0]                  level_c;
  logic [lee_pkg::RAW_PROD_W-1:0] raw_prod;
  logic [lee_pkg::SCALE_W-1:0] raw_scaled;
  logic [7:0]                  raw_lvl;
  logic [7:0]                  raw;
  logic                        strobe;
  logic [16:0]                 elapsed_inc;
  logic [15:0]                 blink_len;

  lee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .num      (op_num_r),
    .den      (op_den_r),
    .quotient (quotient),
    .busy     (div_busy)
  );

  assign sts.div_done = !div_busy;

  // breathe triangle operand
  assign half     = cfg.breathe_period_ms[16:1];
  assign rising   = elapsed_r < {1'b0, half};
  assign bre_op   = rising ? elapsed_r : cfg.breathe_period_ms - elapsed_r;
  assign bre_prod = lee_pkg::NUM_W'(cfg.peak_level) * lee_pkg::NUM_W'(bre_op);

  // battery status; full wins over charging
  assign full     = !in_r.ext_power_lost && (in_r.battery_full || in_r.charge_capped);
  assign charging = !full && !in_r.ext_power_lost && in_r.battery_charging;
  assign stat_on  = cfg.show_status && (cfg.channel ? full : charging);
  assign stat_s   = stat_on ? lee_pkg::STATUS_RAW : 8'd0;
  assign stat_lim = (stat_s > cfg.raw_max) ? cfg.raw_max : stat_s;
  assign stat_num = lee_pkg::NUM_W'(stat_lim) * lee_pkg::NUM_W'(lee_pkg::LEVEL_MAX)
                  + lee_pkg::NUM_W'(cfg.raw_max[7:1]);

  always_comb begin
    num1 = '0;
    den1 = lee_pkg::DEN_W'(1);
    case (cfg.effect_mode)
      lee_pkg::MODE_OFF:     num1 = '0;
      lee_pkg::MODE_STEADY:  num1 = lee_pkg::NUM_W'(cfg.peak_level);
      lee_pkg::MODE_BLINK:   num1 = phase_on_r ? lee_pkg::NUM_W'(cfg.peak_level) : '0;
      lee_pkg::MODE_BREATHE: begin
        num1 = bre_prod;
        den1 = half;
      end
      lee_pkg::MODE_STATUS: begin
        num1 = stat_num;
        den1 = lee_pkg::DEN_W'(cfg.raw_max);
      end
      default: num1 = '0;
    endcase
  end

  always_comb begin
    if (cfg.effect_mode == lee_pkg::MODE_BREATHE &&
        quotient > lee_pkg::NUM_W'(cfg.peak_level)) begin
      level_c = cfg.peak_level;
    end else begin
      level_c = quotient[6:0];
    end
  end

  assign raw_prod = lee_pkg::RAW_PROD_W'(level_c) * lee_pkg::RAW_PROD_W'(cfg.raw_max)
                  + lee_pkg::ROUND_HALF;

  // divide by 100 through the reciprocal
  assign raw_scaled = lee_pkg::SCALE_W'(raw_prod_r) * lee_pkg::SCALE_W'(lee_pkg::RECIP_100);
  assign raw_lvl    = raw_scaled[lee_pkg::RECIP_SH +: 8];

  assign raw    = (cfg.effect_mode == lee_pkg::MODE_STATUS) ? stat_lim : raw_lvl;
  assign strobe = !last_valid_r || (last_raw_r != raw);

  // effect timing advance
  assign elapsed_inc = elapsed_r + 17'd1;
  assign blink_len   = phase_on_r ? cfg.on_time_ms : cfg.off_time_ms;

  always_comb begin
    elapsed_nxt  = elapsed_r;
    phase_on_nxt = phase_on_r;
    if (restart) begin
      elapsed_nxt  = '0;
      phase_on_nxt = 1'b1;
    end else if (cmd.commit) begin
      case (cfg.effect_mode)
        lee_pkg::MODE_BLINK: begin
          if (elapsed_inc >= {1'b0, blink_len}) begin
            elapsed_nxt  = '0;
            phase_on_nxt = !phase_on_r;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        lee_pkg::MODE_BREATHE: begin
          if (elapsed_inc >= cfg.breathe_period_ms) elapsed_nxt = '0;
          else elapsed_nxt = elapsed_inc;
        end
        default: elapsed_nxt = elapsed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      phase_on_r   <= 1'b1;
      last_raw_r   <= '0;
      last_valid_r <= 1'b0;
    end else begin
      elapsed_r  <= elapsed_nxt;
      phase_on_r <= phase_on_nxt;
      if (cmd.commit) begin
        last_raw_r   <= raw;
        last_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_item;
    if (cmd.mul1) begin
      op_num_r <= num1;
      op_den_r <= den1;
    end
    if (cmd.mul2) begin
      level_r    <= level_c;
      raw_prod_r <= raw_prod;
    end
    if (cmd.commit) begin
      out_r.raw_brightness <= raw;
      out_r.user_level     <= level_r;
      out_r.write_strobe   <= strobe;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

FILE: rtl/lee_ctrl.sv
// Controller: sequences capture, the level divide, raw scaling and result load.
// Depends on lee_pkg.
`default_nettype none

module lee_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_stall,
  input  wire lee_pkg::sts_t   sts,
  output logic                 in_stall,
  output logic                 out_valid,
  output lee_pkg::cmd_t        cmd
);

  lee_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lee_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      lee_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = lee_pkg::ST_MUL1;
        end
      end
      lee_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = lee_pkg::ST_START1;
      end
      lee_pkg::ST_START1: begin
        cmd.div_start = 1'b1;
        state_nxt     = lee_pkg::ST_DIV1;
      end
      lee_pkg::ST_DIV1: begin
        if (sts.div_done) state_nxt = lee_pkg::ST_MUL2;
      end
      lee_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = lee_pkg::ST_DONE;
      end
      lee_pkg::ST_DONE: begin
        // load the result register once it is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lee_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lee_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != lee_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/led_effect_engine_top.sv
// Top level of the LED effect engine: config registers, controller, datapath.
// Depends on lee_pkg, lee_cfg, lee_ctrl and lee_dp.
//
// One millisecond tick in, one result out: raw brightness, the same value as a
// user percent level, and a write strobe on the first result after reset and
// whenever the raw value changed. Between acceptance and the result register
// the controller loads the operands, starts one 24-step pass of the restoring
// divider for the effect level, waits for it, scales the level to raw (a
// reciprocal multiply for the divide by 100) and loads the result. in_stall is
// high from acceptance until the result is loaded and drops in the cycle the
// result appears, so a new item is not accepted until the previous result is
// loaded; while an earlier result still waits under out_stall, the load and
// the next acceptance wait too. Configuration writes apply at once and restart
// the effect; they are meant for times when no item is in flight.
`default_nettype none

module led_effect_engine_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lee_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lee_pkg::out_item_t       out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [16:0]         cfg_data
);

  lee_pkg::cfg_t cfg;
  logic          restart;
  lee_pkg::cmd_t cmd;
  lee_pkg::sts_t sts;

  lee_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  lee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lee_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/lee_checker.sv
// Port-level checks for the LED effect engine, bound to the top level.
// Depends on lee_pkg and led_effect_engine_top.
`default_nettype none

module lee_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire lee_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.user_level <= lee_pkg::LEVEL_MAX)
    else $error("user level above full scale");

endmodule

bind led_effect_engine_top lee_checker u_lee_checker (.*);

`default_nettype wire

FILE: tb/sv/led_effect_engine_top_test.sv
// Self-checking testbench for led_effect_engine_top: directed and random tick items
// across every effect and register setting, checked against an in-bench effect predictor.
// Depends on lee_pkg and led_effect_engine_top only.
module led_effect_engine_top_test;
  import lee_pkg::*;

  localparam int TOTAL_TICKS    = 1700;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_MODE;
  logic [16:0] cfg_data = '0;

  led_effect_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and settings
  mode_t       cur_mode;
  int unsigned peak, on_ms, off_ms, period, rmax, elapsed;
  logic        chan, st_en, lit_phase, last_ok;
  logic [7:0]  last_raw;

  in_item_t    tick_q[$];
  out_item_t   brightness_q[$];
  int          ticks_queued = 0;
  int          ticks_in = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          reg_writes = 0;
  int          phase_no = 0;
  int          mode_ticks[5] = '{0, 0, 0, 0, 0};
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_id = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  logic        in_taken = 1'b0;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned scale_level(int unsigned lvl);
    return (lvl * rmax + LEVEL_MAX / 2) / LEVEL_MAX;
  endfunction

  function automatic void model_reset();
    cur_mode  = MODE_STATUS;
    peak      = 0;
    on_ms     = BLINK_MIN;
    off_ms    = BLINK_MIN;
    period    = BREATHE_MIN;
    rmax      = 100;
    chan      = 1'b0;
    st_en     = 1'b0;
    elapsed   = 0;
    lit_phase = 1'b1;
    last_raw  = '0;
    last_ok   = 1'b0;
  endfunction

  function automatic void model_config(reg_idx_t idx, logic [16:0] data);
    case (idx)
      REG_MODE:      cur_mode = (data[2:0] > MODE_STATUS) ? MODE_STATUS : mode_t'(data[2:0]);
      REG_PEAK:      peak = clamp_u(data[6:0], 0, LEVEL_MAX);
      REG_ON_TIME:   on_ms = clamp_u(data[15:0], BLINK_MIN, BLINK_MAX);
      REG_OFF_TIME:  off_ms = clamp_u(data[15:0], BLINK_MIN, BLINK_MAX);
      REG_PERIOD:    period = clamp_u(data[16:0], BREATHE_MIN, MAX_PERIOD_MS);
      REG_RAW_MAX:   rmax = clamp_u(data[7:0], RAW_MAX_MIN, 255);
      REG_CHANNEL:   chan = data[0];
      REG_STATUS_EN: st_en = data[0];
      default: ;
    endcase
    elapsed   = 0;
    lit_phase = 1'b1;
  endfunction

  function automatic out_item_t predict_tick(in_item_t t);
    out_item_t   o;
    int unsigned lvl, raw, len, half, ph, sraw;
    logic        full, charging;
    lvl = 0;
    raw = 0;
    case (cur_mode)
      MODE_STEADY: begin
        lvl = peak;
        raw = scale_level(lvl);
      end
      MODE_BLINK: begin
        len = lit_phase ? on_ms : off_ms;
        lvl = lit_phase ? peak : 0;
        raw = scale_level(lvl);
        elapsed++;
        if (elapsed >= len) begin
          elapsed   = 0;
          lit_phase = !lit_phase;
        end
      end
      MODE_BREATHE: begin
        half = period / 2;
        ph   = elapsed % period;
        lvl  = (ph < half) ? peak * ph / half : peak * (period - ph) / half;
        if (lvl > peak) lvl = peak;
        raw = scale_level(lvl);
        elapsed = (ph + 1 >= period) ? 0 : ph + 1;
      end
      MODE_STATUS: begin
        // full wins over charging
        full     = !t.ext_power_lost && (t.battery_full || t.charge_capped);
        charging = !full && !t.ext_power_lost && t.battery_charging;
        sraw = (st_en && (chan ? full : charging)) ? STATUS_RAW : 0;
        raw  = (sraw > rmax) ? rmax : sraw;
        lvl  = (raw * 100 + rmax / 2) / rmax;
      end
      default: ;
    endcase
    o.raw_brightness = raw[7:0];
    o.user_level     = lvl[6:0];
    o.write_strobe   = !last_ok || (last_raw != raw[7:0]);
    last_raw = raw[7:0];
    last_ok  = 1'b1;
    mode_ticks[cur_mode]++;
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("MISMATCH result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // sender
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_id) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    logic      out_taken;
    if (rst_n) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (in_taken) begin
        brightness_q.push_back(predict_tick(in_item));
        ticks_in++;
      end
      if (out_taken) begin
        results_seen++;
        if (brightness_q.size() == 0) begin
          report_mismatch("unexpected item, raw_brightness", out_item.raw_brightness, 0);
        end else begin
          want = brightness_q.pop_front();
          if (out_item.raw_brightness !== want.raw_brightness)
            report_mismatch("raw_brightness", out_item.raw_brightness, want.raw_brightness);
          if (out_item.user_level !== want.user_level)
            report_mismatch("user_level", out_item.user_level, want.user_level);
          if (out_item.write_strobe !== want.write_strobe)
            report_mismatch("write_strobe", out_item.write_strobe, want.write_strobe);
        end
      end
      if (in_taken || out_taken || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [16:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    model_config(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // call at a rising edge; nibble 0 goes first
  task automatic queue_nibbles(int n, logic [63:0] nib);
    for (int i = 0; i < n; i++) begin
      tick_q.push_back(in_item_t'(nib[4*i +: 4]));
      ticks_queued++;
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (ticks_in != ticks_queued || brightness_q.size() != 0);
  endtask

  function automatic logic [16:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'(LEVEL_MAX);
      2:       return 17'($urandom_range(101, 127));
      default: return 17'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [16:0] pick_raw_max();
    case ($urandom_range(0, 6))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd255;
      3:       return 17'($urandom_range(2, 49));
      default: return 17'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [16:0] pick_blink_ms();
    case ($urandom_range(0, 7))
      0:       return 17'($urandom_range(0, 131071));
      1:       return 17'(BLINK_MAX);
      2:       return 17'($urandom_range(0, 49));
      default: return 17'($urandom_range(50, 90));
    endcase
  endfunction

  function automatic logic [16:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return 17'($urandom_range(0, 131071));
      1:       return 17'(MAX_PERIOD_MS);
      2:       return 17'($urandom_range(0, 99));
      default: return 17'($urandom_range(100, 260));
    endcase
  endfunction

  task automatic random_settings(output int n_ticks);
    int unsigned r;
    if ($urandom_range(0, 3) == 0)
      write_reg(reg_idx_t'($urandom_range(0, 7)), 17'($urandom_range(0, 131071)));
    r = $urandom_range(0, 9);
    if (r == 0) begin
      write_reg(REG_MODE, 17'(MODE_OFF));
      n_ticks = $urandom_range(5, 25);
    end else if (r == 1) begin
      write_reg(REG_MODE, 17'(MODE_STEADY));
      write_reg(REG_PEAK, pick_level());
      write_reg(REG_RAW_MAX, pick_raw_max());
      n_ticks = $urandom_range(5, 25);
    end else if (r < 5) begin
      write_reg(REG_MODE, 17'(MODE_BLINK));
      write_reg(REG_PEAK, pick_level());
      write_reg(REG_ON_TIME, pick_blink_ms());
      write_reg(REG_OFF_TIME, pick_blink_ms());
      write_reg(REG_RAW_MAX, pick_raw_max());
      n_ticks = $urandom_range(60, 200);
    end else if (r < 8) begin
      write_reg(REG_MODE, 17'(MODE_BREATHE));
      write_reg(REG_PEAK, pick_level());
      write_reg(REG_PERIOD, pick_period());
      write_reg(REG_RAW_MAX, pick_raw_max());
      n_ticks = $urandom_range(60, 200);
    end else begin
      // status, with out-of-range mode codes too
      write_reg(REG_MODE, 17'($urandom_range(4, 7)));
      write_reg(REG_CHANNEL, 17'($urandom_range(0, 1)));
      write_reg(REG_STATUS_EN, 17'($urandom_range(0, 3) != 0));
      write_reg(REG_RAW_MAX, pick_raw_max());
      n_ticks = $urandom_range(20, 60);
    end
  endtask

  initial begin
    int n_ticks;
    model_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // status display off after reset, then red channel charging cases
    @(posedge clk);
    queue_nibbles(1, 64'h1);
    drain();
    write_reg(REG_STATUS_EN, 17'd1);
    write_reg(REG_CHANNEL, 17'd0);
    @(posedge clk);
    queue_nibbles(8, 64'h1F01_3591);
    drain();

    // blue channel, mode code clamped, ceiling below status level
    write_reg(REG_CHANNEL, 17'd1);
    write_reg(REG_MODE, 17'h1FFFF);
    write_reg(REG_RAW_MAX, 17'd0);
    @(posedge clk);
    queue_nibbles(3, 64'hE24);
    drain();

    write_reg(REG_MODE, 17'(MODE_STEADY));
    write_reg(REG_PEAK, 17'd127);
    write_reg(REG_RAW_MAX, 17'd255);
    @(posedge clk);
    queue_nibbles(2, 64'hF0);
    drain();

    write_reg(REG_MODE, 17'(MODE_OFF));
    @(posedge clk);
    queue_nibbles(1, 64'h5);
    drain();

    write_reg(REG_MODE, 17'(MODE_BLINK));
    write_reg(REG_PEAK, 17'd50);
    write_reg(REG_RAW_MAX, 17'd100);
    write_reg(REG_ON_TIME, 17'd0);
    write_reg(REG_OFF_TIME, 17'd65535);
    @(posedge clk);
    queue_nibbles(3, 64'h8A3);
    drain();

    write_reg(REG_MODE, 17'(MODE_BREATHE));
    write_reg(REG_PEAK, 17'd100);
    write_reg(REG_PERIOD, 17'd0);
    @(posedge clk);
    queue_nibbles(4, 64'h6C21);
    drain();

    while (ticks_queued < TOTAL_TICKS) begin
      phase_no++;
      random_settings(n_ticks);
      @(posedge clk);
      case (phase_no % 5)
        1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int i = 0; i < n_ticks; i++)
        queue_nibbles(1, 64'($urandom_range(0, 15)));
      if (phase_no % 8 == 3)
        hold_id++;
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d ticks in %0d random phases plus directed cases, %0d register writes",
             ticks_in, phase_no, reg_writes);
    $display("Ticks per effect: off %0d, steady %0d, blink %0d, breathe %0d, status %0d",
             mode_ticks[0], mode_ticks[1], mode_ticks[2], mode_ticks[3], mode_ticks[4]);
    if (errors == 0 && brightness_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lee_pkg.sv
rtl/lee_cfg.sv
rtl/lee_div.sv
rtl/lee_dp.sv
rtl/lee_ctrl.sv
rtl/led_effect_engine_top.sv
rtl/lee_checker.sv
tb/sv/led_effect_engine_top_test.sv
